@@ hw/rtl/efad_pkg.sv @@
package efad_pkg;

    localparam int WIN_DEPTH     = 8;
    localparam int FILL_W        = $clog2(WIN_DEPTH + 1);
    localparam int TURN_SHIFT    = 12;
    localparam int DEG_PER_TURN  = 360;
    localparam int FOLD_LIMIT    = 150;

    localparam logic [7:0] FUNC_CODE  = 8'h03;
    localparam logic [7:0] ADDR_RESET = 8'h01;

    typedef logic [7:0] byte_t;

endpackage

@@ hw/rtl/efad_calc.sv @@
module efad_calc
    import efad_pkg::*;
(
    input  logic signed [31:0] count,
    input  logic signed [32:0] diff,
    output logic signed [15:0] whole_turns,
    output logic signed [9:0]  angle_deg,
    output logic signed [15:0] delta_deg
);

    logic                          cnt_neg;
    logic [31:0]                   cnt_abs;
    logic [31-TURN_SHIFT:0]        turns_mag;
    logic [TURN_SHIFT-1:0]         rem_mag;
    logic [TURN_SHIFT+8:0]         rem_prod;
    logic [8:0]                    angle_mag;
    logic                          diff_neg;
    logic [32:0]                   diff_abs;
    logic [41:0]                   diff_prod;
    logic [41-TURN_SHIFT:0]        delta_mag;

    always_comb
    begin
        cnt_neg   = count[31];
        cnt_abs   = cnt_neg ? (32'd0 - 32'(count)) : 32'(count);
        turns_mag = cnt_abs[31:TURN_SHIFT];
        rem_mag   = cnt_abs[TURN_SHIFT-1:0];
        // x*360 = x*256 + x*64 + x*32 + x*8
        rem_prod  = ((TURN_SHIFT+9)'(rem_mag) << 8) + ((TURN_SHIFT+9)'(rem_mag) << 6)
                  + ((TURN_SHIFT+9)'(rem_mag) << 5) + ((TURN_SHIFT+9)'(rem_mag) << 3);
        angle_mag = rem_prod[TURN_SHIFT+8:TURN_SHIFT];

        whole_turns = cnt_neg ? (16'd0 - turns_mag[15:0]) : turns_mag[15:0];
        angle_deg   = cnt_neg ? (10'd0 - {1'b0, angle_mag}) : {1'b0, angle_mag};

        diff_neg  = diff[32];
        diff_abs  = diff_neg ? (33'd0 - 33'(diff)) : 33'(diff);
        diff_prod = (42'(diff_abs) << 8) + (42'(diff_abs) << 6)
                  + (42'(diff_abs) << 5) + (42'(diff_abs) << 3);
        delta_mag = diff_prod[41:TURN_SHIFT];

        // fold: both signs map to 360 - |d|
        if (delta_mag > (42-TURN_SHIFT)'(FOLD_LIMIT))
        begin
            delta_deg = 16'(DEG_PER_TURN) - delta_mag[15:0];
        end
        else if (diff_neg)
        begin
            delta_deg = 16'd0 - delta_mag[15:0];
        end
        else
        begin
            delta_deg = delta_mag[15:0];
        end
    end

endmodule

@@ hw/rtl/encoder_frame_angle_decoder.sv @@
// channel  | dir | signals                          | contents
// ---------+-----+----------------------------------+-----------------------------------
// s_axis   | in  | s_axis_tvalid/tready/tdata[7:0]  | rx_byte
// m_axis   | out | m_axis_tvalid/tready/tdata[47:0] | whole_turns, angle_deg, delta_deg
// cfg      | in  | cfg_valid/cfg_ready/cfg_data[7:0]| slave_address
//
// One byte per cycle while s_axis_tready is high. On the ninth frame byte the count and
// difference are captured into the frame register; turns, angle and delta are then computed
// into the output register once it is free or being drained, which drives m_axis_tvalid.
// rst_n clears fill, last position and valid flags and sets the address to ADDR_RESET; window bytes are not reset.
// s_axis_tready drops only when both frame and output registers hold unsent results and m_axis_tready is low.
module encoder_frame_angle_decoder
    import efad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] whole_turns, [25:16] angle_deg,
                                        // [41:26] delta_deg, [47:42] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data        // [7:0] slave_address
);

    byte_t               win_reg [WIN_DEPTH];
    logic [FILL_W-1:0]   fill_reg, fill_next;
    byte_t               addr_reg;
    logic [31:0]         last_reg;
    logic                have_last_reg;

    logic                frm_valid_reg, frm_valid_next;
    logic signed [31:0]  frm_count_reg;
    logic signed [32:0]  frm_diff_reg;

    logic                out_valid_reg, out_valid_next;
    logic [47:0]         out_data_reg;

    logic                in_acc;
    logic                win_full;
    logic                is_frame;
    logic                frm_load;
    logic                out_slot;
    logic                out_load;
    logic [31:0]         count_cur;
    logic signed [32:0]  diff_cur;

    logic signed [15:0]  calc_turns;
    logic signed [9:0]   calc_angle;
    logic signed [15:0]  calc_delta;

    assign cfg_ready     = 1'b1;
    assign out_slot      = !out_valid_reg || m_axis_tready;
    assign out_load      = frm_valid_reg && out_slot;
    assign s_axis_tready = !frm_valid_reg || out_slot;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign win_full  = (fill_reg == FILL_W'(WIN_DEPTH));
    assign is_frame  = win_full && (win_reg[0] == addr_reg) && (win_reg[1] == FUNC_CODE);
    assign frm_load  = in_acc && is_frame;
    assign count_cur = {win_reg[5], win_reg[6], win_reg[3], win_reg[4]};
    assign diff_cur  = have_last_reg ? ({count_cur[31], count_cur} - {last_reg[31], last_reg})
                                     : 33'sd0;

    always_comb
    begin
        fill_next = fill_reg;
        if (in_acc)
        begin
            if (!win_full)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            else if (is_frame)
            begin
                fill_next = '0;
            end
        end

        frm_valid_next = frm_valid_reg;
        if (frm_load)
        begin
            frm_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            frm_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            addr_reg      <= ADDR_RESET;
            last_reg      <= '0;
            have_last_reg <= 1'b0;
            frm_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            frm_valid_reg <= frm_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                addr_reg <= cfg_data;
            end
            if (frm_load)
            begin
                last_reg      <= count_cur;
                have_last_reg <= 1'b1;
            end
        end
    end

    // window bytes: append while filling, shift when full and not a frame
    always_ff @(posedge clk)
    begin
        if (in_acc && !win_full)
        begin
            win_reg[fill_reg[FILL_W-2:0]] <= s_axis_tdata;
        end
        else if (in_acc && !is_frame)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_DEPTH-1] <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frm_load)
        begin
            frm_count_reg <= count_cur;
            frm_diff_reg  <= diff_cur;
        end
        if (out_load)
        begin
            out_data_reg <= {6'd0, calc_delta, calc_angle, calc_turns};
        end
    end

    efad_calc u_calc
    (
        .count       (frm_count_reg),
        .diff        (frm_diff_reg),
        .whole_turns (calc_turns),
        .angle_deg   (calc_angle),
        .delta_deg   (calc_delta)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ hw/rtl/efad_checker.sv @@
module efad_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        cfg_ready
);

    logic signed [9:0]  angle;

    assign angle = m_axis_tdata[25:16];

    // stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (angle <= 10'sd359) && (angle >= -10'sd359))
        else $error("angle out of range");

    // a draining output never blocks the input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:42] == 6'd0)
        else $error("tdata padding not zero");

endmodule

bind encoder_frame_angle_decoder efad_checker u_efad_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);

@@ tb/tb_encoder_frame_angle_decoder.sv @@
module tb_encoder_frame_angle_decoder;
    import efad_pkg::*;

    typedef struct packed {
        logic [15:0] turns;
        logic [9:0]  angle;
        logic [15:0] delta;
    } angle_rec_t;

    class angle_scoreboard;
        byte_t       win [WIN_DEPTH];
        int unsigned fill;
        logic [31:0] last_pos;
        bit          have_last;
        byte_t       addr;
        angle_rec_t  pending_angles [$];
        int          errors;

        function new();
            addr      = ADDR_RESET;
            fill      = 0;
            last_pos  = '0;
            have_last = 1'b0;
            errors    = 0;
        endfunction

        function void set_address(byte_t a);
            addr = a;
        endfunction

        // accepted rx byte: fill or slide the window, predict a reading on a frame
        function void note_byte(byte_t b);
            logic [31:0] raw;
            longint      cnt;
            longint      prev;
            longint      trn;
            longint      rem;
            longint      ang;
            longint      dlt;
            longint      per_turn;
            angle_rec_t  r;
            per_turn = longint'(1) << TURN_SHIFT;
            if (fill < WIN_DEPTH)
            begin
                win[fill] = b;
                fill++;
                return;
            end
            if (win[0] != addr || win[1] != FUNC_CODE)
            begin
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                    win[i] = win[i + 1];
                win[WIN_DEPTH - 1] = b;
                return;
            end
            raw  = {win[5], win[6], win[3], win[4]};
            cnt  = longint'($signed(raw));
            trn  = cnt / per_turn;
            rem  = cnt - trn * per_turn;
            ang  = (rem * DEG_PER_TURN) / per_turn;
            prev = have_last ? longint'($signed(last_pos)) : cnt;
            dlt  = ((cnt - prev) * DEG_PER_TURN) / per_turn;
            if (dlt > FOLD_LIMIT)
                dlt = DEG_PER_TURN - dlt;
            else if (dlt < -FOLD_LIMIT)
                dlt = DEG_PER_TURN + dlt;
            last_pos  = raw;
            have_last = 1'b1;
            fill      = 0;
            r.turns   = trn[15:0];
            r.angle   = ang[9:0];
            r.delta   = dlt[15:0];
            pending_angles.push_back(r);
        endfunction

        function void check_reading(logic [47:0] d);
            angle_rec_t e;
            if (pending_angles.size() == 0)
            begin
                $error("unexpected reading %h", d);
                errors++;
                return;
            end
            e = pending_angles.pop_front();
            if (d[15:0] !== e.turns)
            begin
                $error("whole_turns: expected %0d, got %0d", $signed(e.turns), $signed(d[15:0]));
                errors++;
            end
            if (d[25:16] !== e.angle)
            begin
                $error("angle_deg: expected %0d, got %0d", $signed(e.angle), $signed(d[25:16]));
                errors++;
            end
            if (d[41:26] !== e.delta)
            begin
                $error("delta_deg: expected %0d, got %0d", $signed(e.delta), $signed(d[41:26]));
                errors++;
            end
            if (d[47:42] !== 6'd0)
            begin
                $error("pad: expected 0, got %0d", d[47:42]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = 8'd0;

    angle_scoreboard sb = new();
    bit          src_gaps = 1'b1;
    bit          snk_gaps = 1'b1;
    bit          hold_req = 1'b0;
    byte_t       cur_addr = ADDR_RESET;
    logic [31:0] prev_count = '0;
    int          bytes_sent = 0;

    encoder_frame_angle_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic send_byte(byte_t b);
        int gap;
        gap = src_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // count is split b5:b6:b3:b4, high word second
    task automatic send_frame(logic [31:0] c, int unsigned nbytes);
        byte_t fb [9];
        fb[0] = cur_addr;
        fb[1] = FUNC_CODE;
        fb[2] = byte_t'($urandom);
        fb[3] = c[15:8];
        fb[4] = c[7:0];
        fb[5] = c[31:24];
        fb[6] = c[23:16];
        fb[7] = byte_t'($urandom);
        fb[8] = byte_t'($urandom);
        for (int i = 0; i < nbytes; i++)
            send_byte(fb[i]);
        prev_count = c;
    endtask

    function automatic logic [31:0] next_count();
        logic [31:0] specials [10];
        specials = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4095,
                     -32'sd4095, 32'd4096, -32'sd4096, 32'd1707, 32'd1718};
        case ($urandom_range(0, 5))
            0:       return specials[$urandom_range(0, 9)];
            1:       return $urandom;
            default: return prev_count + $urandom_range(0, 4600) - 32'd2300;
        endcase
    endfunction

    task automatic write_address(byte_t a);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_address(a);
        cur_addr = a;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_angles.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_burst(int n);
        int target;
        int fc;
        target = bytes_sent + n;
        while (bytes_sent < target)
        begin
            case ($urandom_range(0, 9))
                7:
                    repeat ($urandom_range(1, 3))
                        send_byte($urandom_range(0, 3) == 0 ? cur_addr : byte_t'($urandom));
                8:
                    send_frame(next_count(), $urandom_range(2, 8));
                9:
                begin
                    send_byte(cur_addr);
                    fc = $urandom_range(0, 255);
                    if (fc == FUNC_CODE)
                        fc = 8'h83;
                    send_byte(byte_t'(fc));
                    repeat (7) send_byte(byte_t'($urandom));
                end
                default:
                    send_frame(next_count(), 9);
            endcase
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            int gap;
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = snk_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            sb.check_reading(m_axis_tdata);
        end
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // filling window, sliding past junk, first frame, extreme counts
        send_byte(8'hFF);
        send_byte(8'h00);
        send_frame(32'h7FFF_FFFF, 9);
        send_frame(32'h8000_0000, 9);
        wait_drained();

        random_burst(250);
        wait_drained();

        write_address(8'h00);
        random_burst(200);
        wait_drained();

        // long output stall against back-to-back frames
        write_address(8'hFF);
        src_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (32) send_frame(next_count(), 9);
        src_gaps = 1'b1;
        wait_drained();

        write_address(byte_t'($urandom));
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        random_burst(150);
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
        wait_drained();

        write_address(ADDR_RESET);
        random_burst(150);
        wait_drained();
        repeat (10) @(posedge clk);

        if (sb.pending_angles.size() != 0)
        begin
            $error("%0d readings never arrived", sb.pending_angles.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
